FILE: sv/sorted_priority_queue_top_assert.svh
// Assertion macros for the sorted priority queue top level.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SPQ_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/spq_pkg.sv
// Shared types, constants and key helper for the sorted priority queue.
package spq_pkg;

    localparam int unsigned CAPACITY_DEF  = 16;
    localparam int unsigned KEY_BYTES_DEF = 8;
    localparam int unsigned KEY_W         = 64;
    localparam int unsigned OCC_W         = 5;

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]       command;
        logic [KEY_W-1:0] key;
    } cmd_word_t;

    typedef struct packed {
        logic             accepted;
        logic             found;
        logic [OCC_W-1:0] occupancy;
        logic [KEY_W-1:0] head_key;
    } rsp_word_t;

    // Per-cell update controls, one set per cell each cycle
    typedef struct packed {
        logic load;        // take the broadcast key
        logic take_left;   // shift toward tail: copy lower neighbor
        logic take_right;  // shift toward head: copy upper neighbor
    } cell_ctrl_t;

    // Key ends at its first zero byte; bytes past nbytes are cleared too
    function automatic logic [KEY_W-1:0] canon_key(input logic [KEY_W-1:0] raw,
                                                   input int unsigned nbytes);
        logic [KEY_W-1:0] res;
        logic             live;
        res  = '0;
        live = 1'b1;
        for (int unsigned i = 0; i < KEY_W / 8; i++) begin
            live = live && (raw[8*i +: 8] != 8'd0) && (i < nbytes);
            if (live) begin
                res[8*i +: 8] = raw[8*i +: 8];
            end
        end
        return res;
    endfunction

endpackage

FILE: sv/spq_cell.sv
// One storage cell of the sorted row: key, valid bit and local compares.
module spq_cell #(
    parameter int unsigned KW = spq_pkg::KEY_BYTES_DEF * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [KW-1:0]     probe_key,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic [KW-1:0]     left_key,
    input  logic              left_valid,
    input  logic [KW-1:0]     right_key,
    input  logic              right_valid,
    output logic [KW-1:0]     key,
    output logic              valid,
    output logic              match,
    output logic              at_or_after
);

    logic [KW-1:0] key_reg;
    logic [KW-1:0] key_next;
    logic          valid_reg;
    logic          valid_next;

    // Local compares against the broadcast key
    assign match       = valid_reg && (key_reg == probe_key);
    assign at_or_after = !valid_reg || (key_reg[7:0] >= probe_key[7:0]);

    // Next contents: load, shift in from a neighbor, or hold
    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctrl.load)
        begin
            key_next   = probe_key;
            valid_next = 1'b1;
        end
        else if (ctrl.take_left)
        begin
            key_next   = left_key;
            valid_next = left_valid;
        end
        else if (ctrl.take_right)
        begin
            key_next   = right_key;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Key payload, no reset
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key   = key_reg;
    assign valid = valid_reg;

endmodule

FILE: sv/sorted_priority_queue_top.sv
// Sorted priority queue: a row of key cells kept in order of first key byte.
// The result word is registered as the sequencer leaves its result step.
// A new command word is taken only in idle, after the compare, update
// and result steps of the last one; the result step waits on rsp_stall.
// Reset: asynchronous, clears all valid bits and the count at once; key
// storage is left as is and needs no clearing pass.
`include "sorted_priority_queue_top_assert.svh"

module sorted_priority_queue_top #(
    parameter int unsigned CAPACITY  = spq_pkg::CAPACITY_DEF,
    parameter int unsigned KEY_BYTES = spq_pkg::KEY_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  spq_pkg::cmd_word_t cmd_word,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output spq_pkg::rsp_word_t rsp_word
);

    localparam int unsigned KW    = KEY_BYTES * 8;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD,
        ST_RES
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                found_reg;
    logic                found_next;
    logic                acc_reg;
    logic                acc_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    spq_pkg::rsp_word_t  rsp_word_reg;
    spq_pkg::rsp_word_t  rsp_word_next;

    logic [1:0]          cmd_reg;
    logic [KW-1:0]       key_reg;
    logic [CAPACITY-1:0] match_reg;
    logic [CAPACITY-1:0] after_reg;

    logic [spq_pkg::KEY_W-1:0] canon_full;
    logic [CAPACITY-1:0]       cell_match;
    logic [CAPACITY-1:0]       cell_after;
    logic [CAPACITY-1:0]       cell_valid;
    logic [KW-1:0]             cell_key [CAPACITY];
    spq_pkg::cell_ctrl_t       cell_ctrl [CAPACITY];

    logic                do_insert;
    logic                do_remove;
    logic                any_match;
    logic [CAPACITY-1:0] below_first;
    logic [CAPACITY-1:0] ins_pos;
    logic                cmd_take;
    logic                rsp_free;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    // Canonical form of the incoming key
    always_comb
    begin
        canon_full = spq_pkg::canon_key(cmd_word.key, KEY_BYTES);
    end

    // Cell row
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KW-1:0] lkey;
        logic          lvalid;
        logic [KW-1:0] rkey;
        logic          rvalid;

        if (i == 0)
        begin : g_head
            assign lkey   = '0;
            assign lvalid = 1'b0;
        end
        else
        begin : g_mid
            assign lkey   = cell_key[i-1];
            assign lvalid = cell_valid[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign rkey   = '0;
            assign rvalid = 1'b0;
        end
        else
        begin : g_inner
            assign rkey   = cell_key[i+1];
            assign rvalid = cell_valid[i+1];
        end

        spq_cell #(
            .KW (KW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .probe_key   (key_reg),
            .ctrl        (cell_ctrl[i]),
            .left_key    (lkey),
            .left_valid  (lvalid),
            .right_key   (rkey),
            .right_valid (rvalid),
            .key         (cell_key[i]),
            .valid       (cell_valid[i]),
            .match       (cell_match[i]),
            .at_or_after (cell_after[i])
        );
    end

    // Insert point: first cell flagged at-or-after (flags are monotone)
    assign ins_pos[0] = after_reg[0];
    for (genvar i = 1; i < CAPACITY; i++)
    begin : g_ins
        assign ins_pos[i] = after_reg[i] && !after_reg[i-1];
    end

    // Cells strictly below the first match; the rest shift toward the head
    assign any_match   = |match_reg;
    assign below_first = (match_reg - CAPACITY'(1)) & ~match_reg;

    assign do_insert = (state_reg == ST_UPD) && (cmd_reg == spq_pkg::CMD_INSERT)
                       && (count_reg < CNT_W'(CAPACITY));
    assign do_remove = (state_reg == ST_UPD) && (cmd_reg == spq_pkg::CMD_REMOVE)
                       && any_match;

    // Per-cell controls
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_ctrl[i].load       = do_insert && ins_pos[i];
            cell_ctrl[i].take_left  = do_insert && after_reg[i] && !ins_pos[i];
            cell_ctrl[i].take_right = do_remove && !below_first[i];
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        found_next     = found_reg;
        acc_next       = acc_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_word_next  = rsp_word_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                found_next = any_match;
                if (cmd_reg == spq_pkg::CMD_INSERT)
                begin
                    acc_next = (count_reg < CNT_W'(CAPACITY));
                end
                else
                begin
                    acc_next = any_match;
                end
                if (do_insert)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                else if (do_remove)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                state_next = ST_RES;
            end
            ST_RES:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_word_next.accepted  = acc_reg;
                    rsp_word_next.found     = found_reg;
                    rsp_word_next.occupancy = spq_pkg::OCC_W'(count_reg);
                    rsp_word_next.head_key  = cell_valid[0]
                                              ? spq_pkg::KEY_W'(cell_key[0]) : '0;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            acc_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            found_reg     <= found_next;
            acc_reg       <= acc_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_word_reg  <= rsp_word_next;
        end
    end

    // Command capture and registered compare flags
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_reg <= cmd_word.command;
            key_reg <= canon_full[KW-1:0];
        end
        if (state_reg == ST_CMP)
        begin
            match_reg <= cell_match;
            after_reg <= cell_after;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // Checks
    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY),
        "count exceeds capacity")
    `SPQ_ASSERT_NOW(a_valid_prefix, 1'b1,
        ((cell_valid & (cell_valid + CAPACITY'(1))) == '0)
        && ($countones(cell_valid) == count_reg),
        "valid bits not a packed prefix matching count")
    `SPQ_ASSERT_NEXT(a_count_step, state_reg != ST_UPD, count_reg == $past(count_reg),
        "count changed outside update step")

endmodule
